FILE: rtl/core/pal22_pkg.sv
// ----------------------------------------------------------------------------
// pal22_pkg
// Shared types and constants of the PAL 2:2 film cadence detector.
// ----------------------------------------------------------------------------
package pal22_pkg;

  localparam int unsigned THR_W   = 25;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned TALLY_W = 10;

  localparam logic signed [THR_W-1:0] DROP_THR_RST = -25'sd2000;
  localparam logic signed [THR_W-1:0] RISE_THR_RST = 25'sd2000;
  localparam logic [CNT_W-1:0]        LOCK_CNT_RST = 8'd4;
  localparam logic [CNT_W-1:0]        MARGIN_RST   = 8'd2;

  // Most negative tally value; the tally saturates there on the way down
  localparam logic signed [TALLY_W-1:0] TALLY_MIN = {1'b1, {(TALLY_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_VIDEO     = 2'd0,
    MODE_FILM_ODD  = 2'd1,
    MODE_FILM_EVEN = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CFG_DROP_THR      = 2'd0,
    CFG_RISE_THR      = 2'd1,
    CFG_LOCK_CNT      = 2'd2,
    CFG_UNLOCK_MARGIN = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_FIELD   = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_e;

  typedef struct packed {
    logic signed [THR_W-1:0] drop_thr;
    logic signed [THR_W-1:0] rise_thr;
    logic [CNT_W-1:0]        lock_cnt;
    logic [CNT_W-1:0]        unlock_margin;
  } pal22_cfg_t;

  // Cadence control state; parity is "none" while par_valid is low
  typedef struct packed {
    logic signed [TALLY_W-1:0] tally;
    logic                      par_valid;
    logic                      par_odd;
    mode_e                     mode;
  } pal22_ctrl_t;

  function automatic logic signed [TALLY_W-1:0] tally_dec(
    input logic signed [TALLY_W-1:0] t
  );
    logic signed [TALLY_W-1:0] r;
    r = t;
    if (t != TALLY_MIN) begin
      r = t - TALLY_W'(1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/pal22_update.sv
// ----------------------------------------------------------------------------
// pal22_update
// Next-state and result logic for one field or restart transaction.
// ----------------------------------------------------------------------------
module pal22_update #(
  parameter int unsigned COMB_BITS = 24
) (
  input  logic                       cmd_i,
  input  logic [COMB_BITS-1:0]       comb_i,
  input  logic                       odd_i,
  input  logic [COMB_BITS-1:0]       prev_comb_i,
  input  logic signed [COMB_BITS:0]  prev_delta_i,
  input  pal22_pkg::pal22_ctrl_t     ctrl_i,
  input  pal22_pkg::pal22_cfg_t      cfg_i,
  output logic [COMB_BITS-1:0]       prev_comb_o,
  output logic signed [COMB_BITS:0]  prev_delta_o,
  output pal22_pkg::pal22_ctrl_t     ctrl_o,
  output pal22_pkg::mode_e           mode_o,
  output logic                       flip_o
);
  import pal22_pkg::*;

  // Compare width covering both the change and the thresholds
  localparam int unsigned DW = COMB_BITS + 1;
  localparam int unsigned CW = (DW > THR_W) ? DW : THR_W;

  logic signed [DW-1:0]      delta;
  logic signed [CW-1:0]      delta_x, prev_x, drop_x, rise_x;
  logic                      is_drop, is_rise, prev_above;
  logic                      same_par;
  logic signed [TALLY_W-1:0] lock_s, target_s, t1, t2;
  pal22_ctrl_t               nxt;

  assign delta   = $signed({1'b0, comb_i}) - $signed({1'b0, prev_comb_i});
  assign delta_x = CW'(delta);
  assign prev_x  = CW'(prev_delta_i);
  assign drop_x  = CW'(cfg_i.drop_thr);
  assign rise_x  = CW'(cfg_i.rise_thr);

  assign is_drop    = delta_x < drop_x;
  assign is_rise    = delta_x > rise_x;
  assign prev_above = prev_x > drop_x;
  assign same_par   = ctrl_i.par_valid && (ctrl_i.par_odd == odd_i);

  assign lock_s   = $signed({{(TALLY_W-CNT_W){1'b0}}, cfg_i.lock_cnt});
  assign target_s = lock_s - $signed({{(TALLY_W-CNT_W){1'b0}}, cfg_i.unlock_margin});

  always_comb begin
    nxt = ctrl_i;
    t1  = ctrl_i.tally;
    t2  = ctrl_i.tally;
    if (cmd_i == CMD_RESTART) begin
      nxt.tally     = '0;
      nxt.par_valid = 1'b0;
      nxt.par_odd   = 1'b0;
    end else if (ctrl_i.mode == MODE_VIDEO) begin
      if (is_drop && prev_above) begin
        if (same_par) begin
          if (ctrl_i.tally < lock_s) begin
            nxt.tally = ctrl_i.tally + TALLY_W'(1);
          end else begin
            nxt.mode = odd_i ? MODE_FILM_ODD : MODE_FILM_EVEN;
          end
        end else begin
          nxt.par_valid = 1'b1;
          nxt.par_odd   = odd_i;
          nxt.tally     = TALLY_W'(1);
        end
      end
    end else begin
      // drop first (contrary parity counts down, same parity counts up), then a rise on the flip field
      if (is_drop) begin
        if (!same_par) begin
          if (prev_above) begin
            t1 = tally_dec(ctrl_i.tally);
          end
        end else if (ctrl_i.tally < lock_s) begin
          t1 = ctrl_i.tally + TALLY_W'(1);
        end
      end
      t2 = t1;
      if (is_rise && prev_above &&
          ((ctrl_i.mode == MODE_FILM_ODD && odd_i) ||
           (ctrl_i.mode == MODE_FILM_EVEN && !odd_i))) begin
        t2 = tally_dec(t1);
      end
      nxt.tally = t2;
      if (t2 == target_s) begin
        nxt.mode      = MODE_VIDEO;
        nxt.tally     = '0;
        nxt.par_valid = 1'b0;
        nxt.par_odd   = 1'b0;
      end
    end
  end

  always_comb begin
    if (cmd_i == CMD_RESTART) begin
      prev_comb_o  = '0;
      prev_delta_o = '0;
    end else begin
      prev_comb_o  = comb_i;
      prev_delta_o = delta;
    end
  end

  assign ctrl_o = nxt;
  assign mode_o = nxt.mode;
  assign flip_o = (cmd_i == CMD_FIELD) &&
                  ((nxt.mode == MODE_FILM_ODD && odd_i) ||
                   (nxt.mode == MODE_FILM_EVEN && !odd_i));

endmodule

FILE: rtl/core/pal_pulldown_22_detector.sv
// ----------------------------------------------------------------------------
// pal_pulldown_22_detector
// PAL 2:2 film cadence detector with stream input and result channels.
// ----------------------------------------------------------------------------
// Usage:
//   One input transaction per video field on s_axis: tdata carries the comb
//   factor and the field parity, tuser the command (new field or restart).
//   Each input transaction gives exactly one result on m_axis: the cadence
//   mode (video, film odd, film even) and a flag to weave and show now.
//   Settings are written over the cfg channel (index 0 drop threshold, 1 rise
//   threshold, 2 lock count, 3 unlock margin); cfg_ready_o is always high.
//   The user must write them only while no field is in flight; not enforced.
// Timing:
//   An input register feeds the update logic, which writes the result
//   register; a receiver stall holds the transaction in the input register.
//   One transaction per cycle is sustained while the receiver takes results;
//   the state update is one compare-and-add pass between those two registers.
// Reset and stall:
//   Reset restores the default settings, video mode and cleared counters.
//   When the receiver stalls, the result holds and one more input is taken
//   into the input register, then s_axis_tready drops until the result moves.
// ----------------------------------------------------------------------------
module pal_pulldown_22_detector #(
  parameter int unsigned COMB_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [COMB_BITS-1:0] comb_factor, [COMB_BITS] field_odd, rest zero
  input  logic [((COMB_BITS+1+7)/8)*8-1:0]    s_axis_tdata,
  // [0] cmd
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [1:0] mode, [2] flip_now, rest zero
  output logic [7:0]                          m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_index_i,
  input  logic [pal22_pkg::THR_W-1:0]         cfg_data_i
);
  import pal22_pkg::*;

  // configuration
  pal22_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drop_thr      <= DROP_THR_RST;
      cfg_q.rise_thr      <= RISE_THR_RST;
      cfg_q.lock_cnt      <= LOCK_CNT_RST;
      cfg_q.unlock_margin <= MARGIN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DROP_THR:      cfg_q.drop_thr      <= $signed(cfg_data_i);
        CFG_RISE_THR:      cfg_q.rise_thr      <= $signed(cfg_data_i);
        CFG_LOCK_CNT:      cfg_q.lock_cnt      <= cfg_data_i[CNT_W-1:0];
        CFG_UNLOCK_MARGIN: cfg_q.unlock_margin <= cfg_data_i[CNT_W-1:0];
      endcase
    end
  end

  // input register
  logic                 in_valid_q;
  logic                 in_cmd_q;
  logic [COMB_BITS-1:0] in_comb_q;
  logic                 in_odd_q;
  logic                 fire;
  logic                 out_valid_q;

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q  <= s_axis_tuser;
      in_comb_q <= s_axis_tdata[COMB_BITS-1:0];
      in_odd_q  <= s_axis_tdata[COMB_BITS];
    end
  end

  // detector state
  logic [COMB_BITS-1:0]      prev_comb_q, prev_comb_d;
  logic signed [COMB_BITS:0] prev_delta_q, prev_delta_d;
  pal22_ctrl_t               ctrl_q, ctrl_d;
  mode_e                     res_mode;
  logic                      res_flip;

  pal22_update #(
    .COMB_BITS(COMB_BITS)
  ) u_update (
    .cmd_i        (in_cmd_q),
    .comb_i       (in_comb_q),
    .odd_i        (in_odd_q),
    .prev_comb_i  (prev_comb_q),
    .prev_delta_i (prev_delta_q),
    .ctrl_i       (ctrl_q),
    .cfg_i        (cfg_q),
    .prev_comb_o  (prev_comb_d),
    .prev_delta_o (prev_delta_d),
    .ctrl_o       (ctrl_d),
    .mode_o       (res_mode),
    .flip_o       (res_flip)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_comb_q  <= '0;
      prev_delta_q <= '0;
      ctrl_q       <= '{tally: '0, par_valid: 1'b0, par_odd: 1'b0, mode: MODE_VIDEO};
    end else if (fire) begin
      prev_comb_q  <= prev_comb_d;
      prev_delta_q <= prev_delta_d;
      ctrl_q       <= ctrl_d;
    end
  end

  // result register
  mode_e out_mode_q;
  logic  out_flip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_mode_q <= res_mode;
      out_flip_q <= res_flip;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_flip_q, out_mode_q};

  // checks
  a_flip_needs_film: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_flip_q && out_mode_q == MODE_VIDEO))
    else $error("flip flagged in video mode");

  a_restart_no_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_cmd_q == CMD_RESTART) |=> (out_valid_q && !out_flip_q))
    else $error("restart result carries a flip");

  a_tally_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q.tally <= $signed(TALLY_W'(255)))
    else $error("tally above lock range");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stalled with empty input register");

endmodule
